[design/atsl_pkg.sv]
// atsl_pkg: shared types and constants for the address-to-symbol lookup block
// no dependencies; used by atsl_scan and address_to_symbol_lookup_core
package atsl_pkg;

  localparam int ADDR_W = 64;
  localparam int IDX_W  = 14;
  localparam int CNT_W  = 15;
  localparam int REG_W  = 3;

  // configuration register indexes
  localparam logic [REG_W-1:0] REG_SYMBOL_COUNT = 3'd0;
  localparam logic [REG_W-1:0] REG_TEXT_START   = 3'd1;
  localparam logic [REG_W-1:0] REG_TEXT_END     = 3'd2;
  localparam logic [REG_W-1:0] REG_INIT_START   = 3'd3;
  localparam logic [REG_W-1:0] REG_INIT_END     = 3'd4;

  // input word modes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0]  symbol_count;
    logic [ADDR_W-1:0] text_start;
    logic [ADDR_W-1:0] text_end;
    logic [ADDR_W-1:0] init_start;
    logic [ADDR_W-1:0] init_end;
  } cfg_t;

  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  symbol_index;
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] symbol_size;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FIRST,
    S_SCAN1,
    S_SCAN2,
    S_OFFSET,
    S_SIZE,
    S_DONE
  } state_t;

endpackage

[design/atsl_ram.sv]
// atsl_ram: generic single write port, single read port ram with registered read
// no dependencies
module atsl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/atsl_scan.sv]
// atsl_scan: lookup sequencer with one shared compare unit and one shared subtractor
// depends on atsl_pkg; reads the address table through a registered-read ram port
module atsl_scan #(
  parameter int TABLE_DEPTH = 16384
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              start,
  input  logic [atsl_pkg::ADDR_W-1:0]                       start_addr,
  input  atsl_pkg::cfg_t                                    cfg,
  output logic                                              busy,
  output logic                                              rd_en,
  output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] rd_addr,
  input  logic [atsl_pkg::ADDR_W-1:0]                       rd_data,
  output logic                                              res_valid,
  input  logic                                              res_ready,
  output atsl_pkg::res_t                                    res
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  atsl_pkg::state_t state_r, state_nxt;
  logic                        pend_r, pend_nxt;
  logic [atsl_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [atsl_pkg::ADDR_W-1:0] base_r, base_nxt;
  logic [atsl_pkg::ADDR_W-1:0] end_r, end_nxt;
  logic [atsl_pkg::ADDR_W-1:0] off_r, off_nxt;
  logic [atsl_pkg::ADDR_W-1:0] size_r, size_nxt;
  logic                        hit_r, hit_nxt;
  logic [AW-1:0]               best_r, best_nxt;
  logic [AW-1:0]               data_idx_r, data_idx_nxt;
  logic [CW-1:0]               rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;

  logic                        in_text, in_init;
  logic [CW+atsl_pkg::CNT_W-1:0] cnt_wide, depth_wide;
  logic [CW-1:0]               cnt_eff;
  logic                        issue;
  logic                        gt_base, le_addr;
  logic [atsl_pkg::ADDR_W-1:0] sub_a, diff;
  logic [AW+atsl_pkg::IDX_W-1:0] best_wide;

  // section membership of the query
  assign in_text = (addr_r >= cfg.text_start) && (addr_r <= cfg.text_end);
  assign in_init = (addr_r >= cfg.init_start) && (addr_r <= cfg.init_end);

  // symbol count saturated at the table depth
  assign cnt_wide   = (CW + atsl_pkg::CNT_W)'(cfg.symbol_count);
  assign depth_wide = (CW + atsl_pkg::CNT_W)'(TABLE_DEPTH);
  assign cnt_eff    = (cnt_wide > depth_wide) ? depth_wide[CW-1:0] : cnt_wide[CW-1:0];

  // shared compare unit on the entry read back
  assign gt_base = rd_data > base_r;
  assign le_addr = rd_data <= addr_r;

  // shared subtractor: offset first, then size
  assign sub_a = (state_r == atsl_pkg::S_OFFSET) ? addr_r : end_r;
  assign diff  = sub_a - base_r;

  assign issue = rd_idx_r < cnt_r;

  // next state and datapath control
  always_comb begin
    state_nxt    = state_r;
    pend_nxt     = pend_r;
    addr_nxt     = addr_r;
    base_nxt     = base_r;
    end_nxt      = end_r;
    off_nxt      = off_r;
    size_nxt     = size_r;
    hit_nxt      = hit_r;
    best_nxt     = best_r;
    data_idx_nxt = data_idx_r;
    rd_idx_nxt   = rd_idx_r;
    cnt_nxt      = cnt_r;
    rd_en        = 1'b0;
    rd_addr      = rd_idx_r[AW-1:0];
    res_valid    = 1'b0;
    unique case (state_r)
      atsl_pkg::S_IDLE: begin
        if (start) begin
          addr_nxt  = start_addr;
          state_nxt = atsl_pkg::S_CHECK;
        end
      end
      atsl_pkg::S_CHECK: begin
        best_nxt = '0;
        pend_nxt = 1'b0;
        if (!in_text && !in_init) begin
          // miss: all result fields zero
          hit_nxt   = 1'b0;
          off_nxt   = '0;
          size_nxt  = '0;
          state_nxt = atsl_pkg::S_DONE;
        end else begin
          // entry 0 is always the first candidate
          rd_en      = 1'b1;
          rd_addr    = '0;
          hit_nxt    = 1'b1;
          end_nxt    = in_init ? cfg.init_end : cfg.text_end;
          cnt_nxt    = cnt_eff;
          rd_idx_nxt = CW'(1);
          state_nxt  = atsl_pkg::S_FIRST;
        end
      end
      atsl_pkg::S_FIRST: begin
        base_nxt = rd_data;
        if (issue) begin
          rd_en        = 1'b1;
          data_idx_nxt = rd_idx_r[AW-1:0];
          pend_nxt     = 1'b1;
          rd_idx_nxt   = rd_idx_r + CW'(1);
        end
        state_nxt = atsl_pkg::S_SCAN1;
      end
      atsl_pkg::S_SCAN1: begin
        // keep the first greatest start not above the query
        if (pend_r && gt_base && le_addr) begin
          best_nxt = data_idx_r;
          base_nxt = rd_data;
        end
        if (issue) begin
          rd_en        = 1'b1;
          data_idx_nxt = rd_idx_r[AW-1:0];
          pend_nxt     = 1'b1;
          rd_idx_nxt   = rd_idx_r + CW'(1);
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          rd_idx_nxt = CW'(best_r) + CW'(1);
          state_nxt  = atsl_pkg::S_SCAN2;
        end
      end
      atsl_pkg::S_SCAN2: begin
        // first later entry strictly above the symbol start ends it
        if (pend_r && gt_base) begin
          end_nxt   = rd_data;
          pend_nxt  = 1'b0;
          state_nxt = atsl_pkg::S_OFFSET;
        end else if (issue) begin
          rd_en        = 1'b1;
          data_idx_nxt = rd_idx_r[AW-1:0];
          pend_nxt     = 1'b1;
          rd_idx_nxt   = rd_idx_r + CW'(1);
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          state_nxt = atsl_pkg::S_OFFSET;
        end
      end
      atsl_pkg::S_OFFSET: begin
        off_nxt   = diff;
        state_nxt = atsl_pkg::S_SIZE;
      end
      atsl_pkg::S_SIZE: begin
        size_nxt  = diff;
        state_nxt = atsl_pkg::S_DONE;
      end
      atsl_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = atsl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = atsl_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= atsl_pkg::S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    base_r     <= base_nxt;
    end_r      <= end_nxt;
    off_r      <= off_nxt;
    size_r     <= size_nxt;
    hit_r      <= hit_nxt;
    best_r     <= best_nxt;
    data_idx_r <= data_idx_nxt;
    rd_idx_r   <= rd_idx_nxt;
    cnt_r      <= cnt_nxt;
  end

  assign busy = (state_r != atsl_pkg::S_IDLE);

  // result word, index masked to the field width
  assign best_wide        = (AW + atsl_pkg::IDX_W)'(best_r);
  assign res.hit          = hit_r;
  assign res.symbol_index = best_wide[atsl_pkg::IDX_W-1:0];
  assign res.offset       = off_r;
  assign res.symbol_size  = size_r;

  // scan reads stay inside the valid entries
  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && state_r != atsl_pkg::S_CHECK) |-> (rd_idx_r < cnt_r))
    else $error("table read beyond symbol count");

  // a miss carries all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res.hit) |->
      (res.offset == '0 && res.symbol_size == '0 && res.symbol_index == '0))
    else $error("miss result with non-zero fields");

  // a waiting result holds until taken
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("result dropped or changed while waiting");

  // best candidate lies among the scanned entries
  a_best_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == atsl_pkg::S_SCAN2) |-> (CW'(best_r) < cnt_r || best_r == '0))
    else $error("best index outside the table");

endmodule

[design/address_to_symbol_lookup_core.sv]
// Load word: written to the table at the accept edge if its index fits the table
// depth; no result. Lookup miss: S_CHECK, then S_DONE, then the output register.
// Lookup hit: time grows with the N stored symbols, set by the single read port
// of the table, scanned once for the best start and again for the next greater one.
// Throughput: one lookup at a time; the next word is taken once the result is
// in the output register. Reset clears control and configuration; table undefined.
module address_to_symbol_lookup_core #(
  parameter int TABLE_DEPTH = 16384
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration port
  input  logic                              cfg_we,
  input  logic [atsl_pkg::REG_W-1:0]        cfg_index,
  input  logic [atsl_pkg::ADDR_W-1:0]       cfg_data,
  // input words
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_mode,
  input  logic [atsl_pkg::IDX_W-1:0]        in_entry_index,
  input  logic [atsl_pkg::ADDR_W-1:0]       in_address,
  // result words
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_hit,
  output logic [atsl_pkg::IDX_W-1:0]        out_symbol_index,
  output logic [atsl_pkg::ADDR_W-1:0]       out_offset,
  output logic [atsl_pkg::ADDR_W-1:0]       out_symbol_size
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  atsl_pkg::cfg_t cfg_r, cfg_nxt;
  atsl_pkg::res_t out_r;
  atsl_pkg::res_t res;
  logic           out_valid_r;

  logic                        in_acc;
  logic                        busy;
  logic                        start;
  logic                        ram_we;
  logic [AW+atsl_pkg::IDX_W-1:0] slot_wide;
  logic                        slot_ok;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [atsl_pkg::ADDR_W-1:0] rd_data;
  logic                        res_valid;
  logic                        res_ready;

  // configuration decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        atsl_pkg::REG_SYMBOL_COUNT: cfg_nxt.symbol_count = cfg_data[atsl_pkg::CNT_W-1:0];
        atsl_pkg::REG_TEXT_START:   cfg_nxt.text_start   = cfg_data;
        atsl_pkg::REG_TEXT_END:     cfg_nxt.text_end     = cfg_data;
        atsl_pkg::REG_INIT_START:   cfg_nxt.init_start   = cfg_data;
        atsl_pkg::REG_INIT_END:     cfg_nxt.init_end     = cfg_data;
        default:                    cfg_nxt              = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // input handshake and word steering
  assign in_stall  = busy;
  assign in_acc    = in_valid && !in_stall;
  assign slot_wide = (AW + atsl_pkg::IDX_W)'(in_entry_index);
  assign slot_ok   = slot_wide < (AW + atsl_pkg::IDX_W)'(TABLE_DEPTH);
  assign ram_we    = in_acc && (in_mode == atsl_pkg::MODE_LOAD) && slot_ok;
  assign start     = in_acc && (in_mode == atsl_pkg::MODE_LOOKUP);

  atsl_ram #(
    .WIDTH (atsl_pkg::ADDR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_wide[AW-1:0]),
    .wdata (in_address),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  atsl_scan #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .start_addr (in_address),
    .cfg        (cfg_r),
    .busy       (busy),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // output register
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_r.hit;
  assign out_symbol_index = out_r.symbol_index;
  assign out_offset       = out_r.offset;
  assign out_symbol_size  = out_r.symbol_size;

endmodule
